// ----- hdl/set_assoc_cache_directory_assert.svh -----
// Assertion macros for the cache directory.
// SACD_ASSERT checks a property with reset masking.
// SACD_ASSERT_ALWAYS checks a property at every rising clock edge.
`ifndef SET_ASSOC_CACHE_DIRECTORY_ASSERT_SVH
`define SET_ASSOC_CACHE_DIRECTORY_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define SACD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define SACD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SACD_ASSERT(lbl, clk, rst_n, prop, msg)

`define SACD_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- hdl/sacd_pkg.sv -----
`default_nettype none

package sacd_pkg;

  // fixed field widths
  localparam int ADDR_W     = 32;
  localparam int CNT_W      = 32;
  localparam int AGE_W      = 32;
  localparam int SLOT_OUT_W = 8;
  localparam int EVT_W      = 21;
  localparam int OUT_W      = 160;

  // read timestamp; wide enough that it never wraps in practice
  localparam int STAMP_W = 64;

  // access kinds
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WB
  } st_t;

endpackage

`default_nettype wire

// ----- hdl/sacd_ram.sv -----
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle.
module sacd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- hdl/set_assoc_cache_directory.sv -----
`default_nettype none

// Tag directory of a WAYS-way set-associative, write-through, no-write-allocate
// cache. An item on the in_ channel is one access (in_tuser: 0 read, 1 write;
// in_tdata: byte address); each access yields one result item on the out_
// channel with hit, line slot (set*WAYS+way), fill and eviction info and the
// four saturating hit/miss counters after the access. Replacement is LRU by
// line age, where age counts reads since the line was last read or filled;
// ages are kept as timestamps against a global read count. Tags and
// timestamps live in one RAM; valid bits are flip-flops cleared at reset, so
// no clearing pass is needed. An access is accepted, then its ways are
// scanned in turn through a single tag/age compare unit fed by the RAM read
// port, and then it is written back. The scan stops at the way that hits.
// Write-back waits while a previous result still sits in the output register.
module set_assoc_cache_directory
  import sacd_pkg::*;
#(
  parameter int WAYS             = 4,
  parameter int SET_INDEX_BITS   = 6,
  parameter int LINE_OFFSET_BITS = 5
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [ADDR_W-1:0] in_tdata,  // [31:0] address
  input  wire logic              in_tuser,  // [0] req_type
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  // [0] hit, [8:1] line_slot, [9] filled, [10] evicted_valid,
  // [31:11] evicted_tag, [63:32] read_hit_count, [95:64] read_miss_count,
  // [127:96] write_hit_count, [159:128] write_miss_count
  output logic      [OUT_W-1:0]  out_tdata
);

  localparam int NUM_LINES = WAYS << SET_INDEX_BITS;
  localparam int SLOT_W    = $clog2(NUM_LINES);
  localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TAG_W     = ADDR_W - LINE_OFFSET_BITS - SET_INDEX_BITS;
  localparam int TAG_LO    = LINE_OFFSET_BITS + SET_INDEX_BITS;
  localparam int ENT_W     = TAG_W + STAMP_W;

  // FSM and access context
  st_t                 state_r, state_nxt;
  logic [WAY_W-1:0]    way_r;
  logic [SLOT_W-1:0]   base_r;
  logic [TAG_W-1:0]    tag_r;
  logic                wr_r;

  // scan results
  logic                hit_r;
  logic [WAY_W-1:0]    hit_way_r;
  logic [WAY_W-1:0]    vict_way_r;
  logic                have_r;
  logic                inv_r;
  logic [AGE_W-1:0]    best_age_r;
  logic [TAG_W-1:0]    vict_tag_r;

  // directory state
  logic [NUM_LINES-1:0] valid_r;
  logic [STAMP_W-1:0]   now_r;
  logic [CNT_W-1:0]     rd_hit_r, rd_miss_r, wr_hit_r, wr_miss_r;

  // output register
  logic                  out_valid_r;
  logic                  out_hit_r;
  logic [SLOT_OUT_W-1:0] out_slot_r;
  logic                  out_fill_r;
  logic                  out_evv_r;
  logic [EVT_W-1:0]      out_evt_r;

  // RAM ports
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  logic [ENT_W-1:0]  ram_wdata;
  logic [SLOT_W-1:0] ram_raddr;
  logic [ENT_W-1:0]  ram_rdata;

  logic              out_free;
  logic              in_acc;
  logic [SLOT_W-1:0] base_in;
  logic [SLOT_W-1:0] cur_slot;
  logic              last_way;

  // per-way compare unit
  logic [TAG_W-1:0]   rd_tag;
  logic [STAMP_W-1:0] rd_stamp;
  logic [STAMP_W-1:0] age_full;
  logic [AGE_W-1:0]   age_sat;
  logic               cur_valid;
  logic               cur_hit;

  // write-back values
  logic [SLOT_W-1:0]            slot_fin;
  logic [SLOT_W+SLOT_OUT_W-1:0] slot_ext;
  logic [TAG_W+EVT_W-1:0]       evt_ext;

  assign out_free = !out_valid_r || out_tready;
  assign in_acc   = in_tvalid && in_tready;
  assign base_in  = SLOT_W'(in_tdata[LINE_OFFSET_BITS +: SET_INDEX_BITS]) * SLOT_W'(WAYS);
  assign cur_slot = base_r + SLOT_W'(way_r);
  assign last_way = (way_r == WAY_W'(WAYS - 1));

  assign rd_tag    = ram_rdata[ENT_W-1:STAMP_W];
  assign rd_stamp  = ram_rdata[STAMP_W-1:0];
  assign age_full  = now_r - rd_stamp;
  assign age_sat   = (|age_full[STAMP_W-1:AGE_W]) ? {AGE_W{1'b1}} : age_full[AGE_W-1:0];
  assign cur_valid = valid_r[cur_slot];
  assign cur_hit   = cur_valid && (rd_tag == tag_r);

  // final slot: hit line, victim on a read miss, zero on a write miss
  always_comb begin
    if (hit_r) begin
      slot_fin = base_r + SLOT_W'(hit_way_r);
    end else if (wr_r == REQ_WRITE) begin
      slot_fin = '0;
    end else begin
      slot_fin = base_r + SLOT_W'(vict_way_r);
    end
  end

  assign slot_ext = {{SLOT_OUT_W{1'b0}}, slot_fin};
  assign evt_ext  = {{EVT_W{1'b0}}, vict_tag_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (cur_hit || last_way) state_nxt = ST_WB;
      end
      ST_WB: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_tready = 1'b0;
    ram_we    = 1'b0;
    ram_raddr = cur_slot + SLOT_W'(1);
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        ram_raddr = base_in;
      end
      ST_SCAN: begin
        ram_raddr = cur_slot + SLOT_W'(1);
      end
      ST_WB: begin
        ram_we = out_free && (wr_r == REQ_READ);
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  assign ram_waddr = slot_fin;
  assign ram_wdata = {tag_r, now_r};

  sacd_ram #(
    .WIDTH(ENT_W),
    .DEPTH(NUM_LINES)
  ) u_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  // saturating counter step
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (&v) ? v : v + CNT_W'(1);
  endfunction

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // access capture and way scan
  always_ff @(posedge clk) begin
    if (in_acc) begin
      base_r <= base_in;
      tag_r  <= in_tdata[ADDR_W-1:TAG_LO];
      wr_r   <= in_tuser;
      way_r  <= '0;
      hit_r  <= 1'b0;
      have_r <= 1'b0;
      inv_r  <= 1'b0;
    end else if (state_r == ST_SCAN) begin
      way_r <= way_r + WAY_W'(1);
      if (cur_hit) begin
        hit_r     <= 1'b1;
        hit_way_r <= way_r;
      end
      // victim: first invalid way, else oldest valid way, lowest way on ties
      if (!inv_r) begin
        if (!cur_valid) begin
          inv_r      <= 1'b1;
          vict_way_r <= way_r;
        end else if (!have_r || (age_sat > best_age_r)) begin
          have_r     <= 1'b1;
          vict_way_r <= way_r;
          best_age_r <= age_sat;
          vict_tag_r <= rd_tag;
        end
      end
    end
  end

  // directory state and counters, updated at write-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      now_r     <= '0;
      rd_hit_r  <= '0;
      rd_miss_r <= '0;
      wr_hit_r  <= '0;
      wr_miss_r <= '0;
    end else if ((state_r == ST_WB) && out_free) begin
      if (wr_r == REQ_WRITE) begin
        if (hit_r) wr_hit_r <= sat_inc(wr_hit_r);
        else       wr_miss_r <= sat_inc(wr_miss_r);
      end else begin
        if (hit_r) rd_hit_r <= sat_inc(rd_hit_r);
        else       rd_miss_r <= sat_inc(rd_miss_r);
        valid_r[slot_fin] <= 1'b1;
        now_r             <= now_r + STAMP_W'(1);
      end
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_WB) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if ((state_r == ST_WB) && out_free) begin
      out_hit_r  <= hit_r;
      out_slot_r <= slot_ext[SLOT_OUT_W-1:0];
      out_fill_r <= !hit_r && (wr_r == REQ_READ);
      out_evv_r  <= !hit_r && (wr_r == REQ_READ) && !inv_r;
      out_evt_r  <= (!hit_r && (wr_r == REQ_READ) && !inv_r) ? evt_ext[EVT_W-1:0] : '0;
    end
  end

  // counters stay put until the held result is taken
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {wr_miss_r, wr_hit_r, rd_miss_r, rd_hit_r,
                       out_evt_r, out_evv_r, out_fill_r, out_slot_r, out_hit_r};

`include "set_assoc_cache_directory_assert.svh"

  `SACD_ASSERT(a_out_from_wb, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == ST_WB), "result without write-back")
  `SACD_ASSERT(a_fill_not_hit, clk, rst_n, out_valid_r |-> !(out_hit_r && out_fill_r), "fill on a hit")
  `SACD_ASSERT(a_evict_needs_fill, clk, rst_n, (out_valid_r && out_evv_r) |-> out_fill_r, "eviction without fill")
  `SACD_ASSERT(a_ram_we_wb, clk, rst_n, ram_we |-> (state_r == ST_WB) && (wr_r == REQ_READ), "tag write outside read write-back")
  `SACD_ASSERT(a_scan_way_range, clk, rst_n, (state_r == ST_SCAN) |-> (way_r <= WAY_W'(WAYS - 1)), "way index out of range")

endmodule

`default_nettype wire
